/* sv/bma_pkg.sv */
// Package for the bit-manipulation ALU: operation codes and the beat types
// of the input and result channels. Depends on nothing.
`default_nettype none

package bma_pkg;

  localparam logic [4:0] CMD_ANDN   = 5'd0;
  localparam logic [4:0] CMD_ORN    = 5'd1;
  localparam logic [4:0] CMD_XNOR   = 5'd2;
  localparam logic [4:0] CMD_CLZ    = 5'd3;
  localparam logic [4:0] CMD_CLZW   = 5'd4;
  localparam logic [4:0] CMD_CTZ    = 5'd5;
  localparam logic [4:0] CMD_CTZW   = 5'd6;
  localparam logic [4:0] CMD_CPOP   = 5'd7;
  localparam logic [4:0] CMD_CPOPW  = 5'd8;
  localparam logic [4:0] CMD_MAX    = 5'd9;
  localparam logic [4:0] CMD_MAXU   = 5'd10;
  localparam logic [4:0] CMD_MIN    = 5'd11;
  localparam logic [4:0] CMD_MINU   = 5'd12;
  localparam logic [4:0] CMD_ORC_B  = 5'd13;
  localparam logic [4:0] CMD_REV8   = 5'd14;
  localparam logic [4:0] CMD_ROL    = 5'd15;
  localparam logic [4:0] CMD_ROLW   = 5'd16;
  localparam logic [4:0] CMD_ROR    = 5'd17;
  localparam logic [4:0] CMD_RORW   = 5'd18;
  localparam logic [4:0] CMD_SEXT_B = 5'd19;
  localparam logic [4:0] CMD_SEXT_H = 5'd20;
  localparam logic [4:0] CMD_ZEXT_H = 5'd21;

  typedef struct packed {
    logic [4:0]  cmd;
    logic [63:0] operand_a;
    logic [63:0] operand_b;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] result_value;
    logic        illegal_op;
  } out_beat_t;

endpackage

`default_nettype wire

/* sv/bma_compute.sv */
// Combinational datapath of the bit-manipulation ALU: one operation on a
// registered input beat at the configured register width. Uses bma_pkg.
`default_nettype none

module bma_compute (
  input  bma_pkg::in_beat_t  beat_i,
  input  logic               wide_i,
  output bma_pkg::out_beat_t beat_o
);
  import bma_pkg::*;

  function automatic logic [6:0] tz65(input logic [64:0] v);
    logic [64:0] iso;
    logic [6:0]  idx;
    iso = v & (~v + 65'd1);
    idx = '0;
    for (int i = 0; i < 65; i++) begin
      if (iso[i]) idx = idx | 7'(i);
    end
    return idx;
  endfunction

  function automatic logic [6:0] pop64(input logic [63:0] x);
    logic [3:0] bc [8];
    logic [6:0] sum;
    sum = '0;
    for (int k = 0; k < 8; k++) begin
      bc[k] = '0;
      for (int j = 0; j < 8; j++) begin
        bc[k] = bc[k] + 4'(x[8*k+j]);
      end
    end
    for (int k = 0; k < 8; k++) begin
      sum = sum + 7'(bc[k]);
    end
    return sum;
  endfunction

  logic [63:0]  m, a, b, r_raw;
  logic [31:0]  a32, rev32, bswap32, rol32, ror32;
  logic [63:0]  rev64, bswap64, rol64, ror64, orc;
  logic [127:0] dl64, dr64;
  logic [63:0]  dl32, dr32;
  logic [6:0]   clz_n, clzw_n, ctz_n, ctzw_n, cpop_n, cpopw_n;
  logic         lt_s, lt_u, illegal;

  assign m   = wide_i ? {64{1'b1}} : {32'b0, {32{1'b1}}};
  assign a   = beat_i.operand_a & m;
  assign b   = beat_i.operand_b & m;
  assign a32 = beat_i.operand_a[31:0];

  always_comb begin
    for (int i = 0; i < 64; i++) rev64[i] = a[63-i];
    for (int i = 0; i < 32; i++) rev32[i] = a32[31-i];
    for (int k = 0; k < 8; k++) begin
      bswap64[8*k +: 8] = a[8*(7-k) +: 8];
      orc[8*k +: 8]     = {8{|a[8*k +: 8]}};
    end
    for (int k = 0; k < 4; k++) bswap32[8*k +: 8] = a32[8*(3-k) +: 8];
  end

  assign clz_n   = wide_i ? tz65({1'b1, rev64}) : tz65({33'd1, rev32});
  assign clzw_n  = tz65({33'd1, rev32});
  assign ctz_n   = wide_i ? tz65({1'b1, a}) : tz65({33'd1, a32});
  assign ctzw_n  = tz65({33'd1, a32});
  assign cpop_n  = pop64(a);
  assign cpopw_n = pop64({32'b0, a32});

  assign dl64  = {a, a} << beat_i.operand_b[5:0];
  assign dr64  = {a, a} >> beat_i.operand_b[5:0];
  assign dl32  = {a32, a32} << beat_i.operand_b[4:0];
  assign dr32  = {a32, a32} >> beat_i.operand_b[4:0];
  assign rol64 = dl64[127:64];
  assign ror64 = dr64[63:0];
  assign rol32 = dl32[63:32];
  assign ror32 = dr32[31:0];

  assign lt_u = a < b;
  assign lt_s = wide_i ? ($signed(a) < $signed(b))
                       : ($signed(a[31:0]) < $signed(b[31:0]));

  always_comb begin
    illegal = (beat_i.cmd > CMD_ZEXT_H) ||
              (!wide_i && (beat_i.cmd inside {CMD_CLZW, CMD_CTZW, CMD_CPOPW,
                                              CMD_ROLW, CMD_RORW}));
    case (beat_i.cmd)
      CMD_ANDN:   r_raw = a & ~b;
      CMD_ORN:    r_raw = a | ~b;
      CMD_XNOR:   r_raw = ~(a ^ b);
      CMD_CLZ:    r_raw = {57'b0, clz_n};
      CMD_CLZW:   r_raw = {57'b0, clzw_n};
      CMD_CTZ:    r_raw = {57'b0, ctz_n};
      CMD_CTZW:   r_raw = {57'b0, ctzw_n};
      CMD_CPOP:   r_raw = {57'b0, cpop_n};
      CMD_CPOPW:  r_raw = {57'b0, cpopw_n};
      CMD_MAX:    r_raw = lt_s ? b : a;
      CMD_MAXU:   r_raw = lt_u ? b : a;
      CMD_MIN:    r_raw = lt_s ? a : b;
      CMD_MINU:   r_raw = lt_u ? a : b;
      CMD_ORC_B:  r_raw = orc;
      CMD_REV8:   r_raw = wide_i ? bswap64 : {32'b0, bswap32};
      CMD_ROL:    r_raw = wide_i ? rol64 : {32'b0, rol32};
      CMD_ROLW:   r_raw = {{32{rol32[31]}}, rol32};
      CMD_ROR:    r_raw = wide_i ? ror64 : {32'b0, ror32};
      CMD_RORW:   r_raw = {{32{ror32[31]}}, ror32};
      CMD_SEXT_B: r_raw = {{56{a[7]}}, a[7:0]};
      CMD_SEXT_H: r_raw = {{48{a[15]}}, a[15:0]};
      CMD_ZEXT_H: r_raw = {48'b0, a[15:0]};
      default:    r_raw = '0;
    endcase
    beat_o.illegal_op   = illegal;
    beat_o.result_value = illegal ? 64'b0 : (r_raw & m);
  end

endmodule

`default_nettype wire

/* sv/bitmanip_basic_alu.sv */
// Top level of the bit-manipulation ALU: input register, datapath and result
// register, plus the register-width setting. Uses bma_pkg and bma_compute.
//
// Usage: drive in_beat and raise start; a beat is taken at each rising edge
// where start is high and busy is low. Busy is low in every cycle outside
// reset, so a new beat can be issued every cycle.
// Each beat produces one result beat on out_beat, marked by out_valid for
// exactly one cycle, once the beat has passed the input register and then
// the result register, with the whole operation done in the logic between
// them; throughput is one beat per cycle. The receiver cannot stall: each
// result must be taken in the cycle it is shown.
// cfg_we with cfg_wdata sets the register width (0: 32-bit, 1: 64-bit);
// write it only while no beat is in flight.
// Synchronous reset empties the pipeline, drops out_valid and selects
// 64-bit width; busy is high while rst_n is low.
`default_nettype none

module bitmanip_basic_alu (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  bma_pkg::in_beat_t  in_beat,
  output logic               out_valid,
  output bma_pkg::out_beat_t out_beat,
  input  logic               cfg_we,
  input  logic               cfg_wdata
);
  import bma_pkg::*;

  logic      wide_mode_r;
  logic      in_valid_r;
  in_beat_t  in_beat_r;
  logic      out_valid_r;
  out_beat_t out_beat_r;
  out_beat_t out_beat_nxt;

  assign busy = !rst_n;

  bma_compute u_compute (
    .beat_i (in_beat_r),
    .wide_i (wide_mode_r),
    .beat_o (out_beat_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_mode_r <= 1'b1;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) wide_mode_r <= cfg_wdata;
      in_valid_r  <= start && !busy;
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) in_beat_r <= in_beat;
    if (in_valid_r) out_beat_r <= out_beat_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule

`default_nettype wire

/* sv/bma_checker.sv */
// Port-level checks for the bit-manipulation ALU and the bind that attaches
// them to bitmanip_basic_alu. Uses bma_pkg.
`default_nettype none

module bma_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input bma_pkg::in_beat_t  in_beat,
  input logic               out_valid,
  input bma_pkg::out_beat_t out_beat
);
  import bma_pkg::*;

  a_no_stall: assert property (@(posedge clk) rst_n |-> !busy)
    else $error("busy raised outside reset");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result beat without a matching input beat");

  a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    $past(start && !busy, 2) && $past(rst_n) |-> out_valid)
    else $error("input beat produced no result beat");

  a_illegal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beat.illegal_op |-> out_beat.result_value == 64'b0)
    else $error("illegal result beat carries a nonzero value");

  a_bad_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ($past(in_beat.cmd, 2) > CMD_ZEXT_H) |-> out_beat.illegal_op)
    else $error("undefined code not flagged illegal");

endmodule

bind bitmanip_basic_alu bma_checker u_bma_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_beat   (in_beat),
  .out_valid (out_valid),
  .out_beat  (out_beat)
);

`default_nettype wire

/* bench/tb_bitmanip_basic_alu.sv */
// Self-checking bench for bitmanip_basic_alu: directed and random Zbb beats in both register widths,
// each result compared with an in-bench ALU model. Depends on bma_pkg and the block's top level.
`timescale 1ns / 1ps

module tb_bitmanip_basic_alu;
  import bma_pkg::*;

  localparam logic [4:0] CMD_UNDEF_LO = 5'd22;
  localparam logic [4:0] CMD_UNDEF_HI = 5'd31;
  localparam int         IDLE_LIMIT   = 1000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_beat_t  in_beat = '0;
  logic      out_valid;
  out_beat_t out_beat;
  logic      cfg_we = 1'b0;
  logic      cfg_wdata = 1'b0;

  logic      mode_wide = 1'b1;
  in_beat_t  op_queue[$];
  out_beat_t alu_expected[$];
  out_beat_t want;
  int        n_issued = 0;
  int        n_checked = 0;
  int        n_fail = 0;
  int        gap_left = 0;
  bit        no_gap = 1'b0;
  int        idle_cycles = 0;

  bitmanip_basic_alu i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_beat  (out_beat),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [63:0] rotl(logic [63:0] x, int s, int w);
    logic [63:0] m;
    int          sh;
    m = (w == 64) ? '1 : 64'h0000_0000_FFFF_FFFF;
    sh = s & (w - 1);
    x = x & m;
    if (sh == 0) return x;
    return ((x << sh) | (x >> (w - sh))) & m;
  endfunction

  function automatic logic [63:0] sext(logic [63:0] x, int from);
    logic [63:0] m;
    logic [63:0] sb;
    m = (64'h1 << from) - 64'h1;
    sb = 64'h1 << (from - 1);
    x = x & m;
    return ((x & sb) != 0) ? (x | ~m) : x;
  endfunction

  function automatic logic [63:0] lead_zeros(logic [63:0] x, int w);
    logic [63:0] n;
    bit          hit;
    n = '0;
    hit = 1'b0;
    for (int i = w - 1; i >= 0; i--) begin
      if (!hit) begin
        if (x[i]) hit = 1'b1;
        else n++;
      end
    end
    return n;
  endfunction

  function automatic logic [63:0] trail_zeros(logic [63:0] x, int w);
    logic [63:0] n;
    bit          hit;
    n = '0;
    hit = 1'b0;
    for (int i = 0; i < w; i++) begin
      if (!hit) begin
        if (x[i]) hit = 1'b1;
        else n++;
      end
    end
    return n;
  endfunction

  function automatic logic [63:0] ones(logic [63:0] x, int w);
    logic [63:0] n;
    n = '0;
    for (int i = 0; i < w; i++) n += x[i];
    return n;
  endfunction

  function automatic out_beat_t alu_result(in_beat_t it, logic wide);
    int          w;
    logic [63:0] m;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] a32;
    logic [63:0] r;
    logic [63:0] sb;
    bit          lt_s;
    out_beat_t   o;
    w = wide ? 64 : 32;
    m = wide ? '1 : 64'h0000_0000_FFFF_FFFF;
    a = it.operand_a & m;
    b = it.operand_b & m;
    a32 = {32'h0, it.operand_a[31:0]};
    sb = 64'h1 << (w - 1);
    lt_s = ((a ^ sb) & m) < ((b ^ sb) & m);
    r = '0;
    o.result_value = '0;
    o.illegal_op = 1'b1;
    if (it.cmd > CMD_ZEXT_H) return o;
    if (!wide && (it.cmd == CMD_CLZW || it.cmd == CMD_CTZW || it.cmd == CMD_CPOPW ||
                  it.cmd == CMD_ROLW || it.cmd == CMD_RORW)) return o;
    case (it.cmd)
      CMD_ANDN:   r = a & ~b;
      CMD_ORN:    r = a | ~b;
      CMD_XNOR:   r = ~(a ^ b);
      CMD_CLZ:    r = lead_zeros(a, w);
      CMD_CLZW:   r = lead_zeros(a32, 32);
      CMD_CTZ:    r = trail_zeros(a, w);
      CMD_CTZW:   r = trail_zeros(a32, 32);
      CMD_CPOP:   r = ones(a, w);
      CMD_CPOPW:  r = ones(a32, 32);
      CMD_MAX:    r = lt_s ? b : a;
      CMD_MAXU:   r = (a < b) ? b : a;
      CMD_MIN:    r = lt_s ? a : b;
      CMD_MINU:   r = (a < b) ? a : b;
      CMD_ORC_B: begin
        for (int i = 0; i < w; i += 8) begin
          if (a[i +: 8] != 8'h00) r[i +: 8] = 8'hFF;
        end
      end
      CMD_REV8: begin
        for (int i = 0; i < w; i += 8) r[w - 8 - i +: 8] = a[i +: 8];
      end
      CMD_ROL:    r = rotl(a, int'(b[5:0]), w);
      CMD_ROLW:   r = sext(rotl(a32, int'(b[4:0]), 32), 32);
      CMD_ROR:    r = rotl(a, w - (int'(b[5:0]) & (w - 1)), w);
      CMD_RORW:   r = sext(rotl(a32, 32 - int'(b[4:0]), 32), 32);
      CMD_SEXT_B: r = sext(a, 8);
      CMD_SEXT_H: r = sext(a, 16);
      default:    r = {48'h0, a[15:0]};
    endcase
    o.result_value = r & m;
    o.illegal_op = 1'b0;
    return o;
  endfunction

  function automatic in_beat_t mk_op(logic [4:0] c, logic [63:0] a, logic [63:0] b);
    in_beat_t it;
    it.cmd = c;
    it.operand_a = a;
    it.operand_b = b;
    return it;
  endfunction

  function automatic logic [63:0] rand_operand();
    logic [63:0] v;
    int          k;
    k = $urandom_range(0, 63);
    v = {$urandom, $urandom};
    case ($urandom_range(0, 8))
      0: v = '0;
      1: v = '1;
      2: v = 64'h1 << k;
      3: v = ~(64'h1 << k);
      4: v = 64'($urandom_range(0, 255));
      5: begin
        v = '0;
        for (int j = 0; j < 8; j++) begin
          if ($urandom_range(0, 1) == 1) v[j * 8 +: 8] = 8'($urandom_range(1, 255));
        end
      end
      6: v = {($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'h0, $urandom};
      7: v = v >> k;
      default: ;
    endcase
    return v;
  endfunction

  task automatic queue_random(int n);
    logic [4:0]  c;
    logic [63:0] a;
    logic [63:0] b;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) c = 5'($urandom_range(CMD_UNDEF_LO, CMD_UNDEF_HI));
      else c = 5'($urandom_range(CMD_ANDN, CMD_ZEXT_H));
      a = rand_operand();
      case ($urandom_range(0, 5))
        0: b = a;
        1: b = a ^ (64'h1 << $urandom_range(0, 63));
        default: b = rand_operand();
      endcase
      op_queue.push_back(mk_op(c, a, b));
    end
  endtask

  task automatic drain();
    while (op_queue.size() != 0 || n_checked != n_issued) @(posedge clk);
  endtask

  task automatic set_width(logic v);
    drain();
    repeat (3) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    mode_wide = v;
  endtask

  // Driver: a beat is taken on an edge with start high and busy low.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      if (start && !busy) alu_expected.push_back(alu_result(in_beat, mode_wide));
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (op_queue.size() != 0) begin
          in_beat <= op_queue.pop_front();
          start <= 1'b1;
          n_issued++;
          if ($urandom_range(0, 31) == 0) no_gap = !no_gap;
          gap_left = no_gap ? 0 : $urandom_range(0, 14);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (alu_expected.size() == 0) begin
        $error("unexpected result beat: result_value %h illegal_op %b",
               out_beat.result_value, out_beat.illegal_op);
        n_fail++;
      end else begin
        want = alu_expected.pop_front();
        if (out_beat.result_value !== want.result_value) begin
          $error("result_value: expected %h, got %h", want.result_value,
                 out_beat.result_value);
          n_fail++;
        end
        if (out_beat.illegal_op !== want.illegal_op) begin
          $error("illegal_op: expected %b, got %b", want.illegal_op, out_beat.illegal_op);
          n_fail++;
        end
        n_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    op_queue.push_back(mk_op(CMD_ANDN, '1, 64'h00FF_00FF_00FF_00FF));
    op_queue.push_back(mk_op(CMD_ORN, '0, 64'h0F0F_0F0F_0F0F_0F0F));
    op_queue.push_back(mk_op(CMD_XNOR, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555));
    op_queue.push_back(mk_op(CMD_CLZ, '0, '0));
    op_queue.push_back(mk_op(CMD_CLZW, 64'hFFFF_FFFF_0000_0000, '1));
    op_queue.push_back(mk_op(CMD_CTZ, '0, '1));
    op_queue.push_back(mk_op(CMD_CTZW, 64'h8000_0000_0000_0000, '0));
    op_queue.push_back(mk_op(CMD_CPOP, '1, '0));
    op_queue.push_back(mk_op(CMD_CPOPW, '1, '1));
    op_queue.push_back(mk_op(CMD_MAX, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF));
    op_queue.push_back(mk_op(CMD_MAXU, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF));
    op_queue.push_back(mk_op(CMD_MIN, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF));
    op_queue.push_back(mk_op(CMD_MINU, '1, '0));
    op_queue.push_back(mk_op(CMD_ORC_B, 64'h0100_0000_00FF_0000, '0));
    op_queue.push_back(mk_op(CMD_REV8, 64'h0123_4567_89AB_CDEF, '0));
    op_queue.push_back(mk_op(CMD_ROL, 64'h8000_0000_0000_0001, 64'd63));
    op_queue.push_back(mk_op(CMD_ROLW, 64'h0000_0000_8000_0001, 64'd31));
    op_queue.push_back(mk_op(CMD_ROR, 64'h8000_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFC0));
    op_queue.push_back(mk_op(CMD_RORW, 64'h1, 64'h1));
    op_queue.push_back(mk_op(CMD_SEXT_B, 64'h80, '0));
    op_queue.push_back(mk_op(CMD_SEXT_H, 64'h8000, '0));
    op_queue.push_back(mk_op(CMD_ZEXT_H, '1, '1));
    op_queue.push_back(mk_op(CMD_UNDEF_HI, '1, '1));

    set_width(1'b0);
    op_queue.push_back(mk_op(CMD_CLZW, '0, '0));
    op_queue.push_back(mk_op(CMD_RORW, '1, 64'h1));
    op_queue.push_back(mk_op(CMD_CLZ, 64'hFFFF_FFFF_0000_0000, '0));
    op_queue.push_back(mk_op(CMD_ROL, 64'hFFFF_FFFF_8000_0000, 64'd33));
    queue_random(140);

    set_width(1'b1);
    queue_random(140);
    set_width(1'b0);
    queue_random(130);
    set_width(1'b1);
    queue_random(130);

    drain();
    repeat (8) @(posedge clk);
    if (n_fail == 0 && alu_expected.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
